FILE: sv/sha256_pkg.sv
package sha256_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef struct packed {
        logic load_byte;
        logic load_pad;
        logic load_zero;
        logic load_len;
        logic start_comp;
        logic round_step;
        logic finish_comp;
        logic reset_msg;
        logic clear_fill;
        logic out_shift;
    } dp_cmd_t;

    typedef struct packed {
        logic       block_full;
        logic       rounds_done;
        logic [5:0] fill;
    } dp_status_t;

    localparam logic [5:0] LengthPos = 6'd56;
    localparam logic [7:0] PadMark   = 8'h80;

    localparam logic [255:0] InitialH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: sv/sha256_datapath.sv
module sha256_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             byte_in,
    input  sha256_pkg::dp_cmd_t    cmd,
    output sha256_pkg::dp_status_t status,
    output logic [31:0]            head_word
);
    import sha256_pkg::*;

    // block buffer held as 16 schedule words, bytes shifted in big-endian
    logic [511:0] blk_reg, blk_next;
    logic [255:0] chain_reg, chain_next;
    logic [255:0] vars_reg, vars_next;
    logic [6:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [5:0]   round_reg, round_next;
    logic [7:0]   len_byte;
    logic [31:0]  w, s0, s1, w15, w2, t1, t2, a, e, b, c, d, f, g, h;

    always_comb
    begin
        len_byte = bits_reg[63:56];
        unique case (fill_reg[2:0])
            3'd0: len_byte = bits_reg[63:56];
            3'd1: len_byte = bits_reg[55:48];
            3'd2: len_byte = bits_reg[47:40];
            3'd3: len_byte = bits_reg[39:32];
            3'd4: len_byte = bits_reg[31:24];
            3'd5: len_byte = bits_reg[23:16];
            3'd6: len_byte = bits_reg[15:8];
            3'd7: len_byte = bits_reg[7:0];
            default: len_byte = 8'h00;
        endcase
    end

    assign w15 = blk_reg[479:448];
    assign w2  = blk_reg[63:32];
    assign s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
    assign s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
    assign w   = blk_reg[511:480];
    assign {a, b, c, d, e, f, g, h} = vars_reg;
    assign t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + round_k(round_reg) + w;
    assign t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

    always_comb
    begin
        blk_next   = blk_reg;
        chain_next = chain_reg;
        vars_next  = vars_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        round_next = round_reg;
        if (cmd.load_byte)
        begin
            blk_next  = {blk_reg[503:0], byte_in};
            fill_next = fill_reg + 7'd1;
            bits_next = bits_reg + 64'd8;
        end
        if (cmd.load_pad)
        begin
            blk_next  = {blk_reg[503:0], PadMark};
            fill_next = fill_reg + 7'd1;
        end
        if (cmd.load_zero)
        begin
            blk_next  = {blk_reg[503:0], 8'h00};
            fill_next = fill_reg + 7'd1;
        end
        if (cmd.load_len)
        begin
            blk_next  = {blk_reg[503:0], len_byte};
            fill_next = fill_reg + 7'd1;
        end
        if (cmd.start_comp)
        begin
            vars_next  = chain_reg;
            round_next = '0;
        end
        if (cmd.round_step)
        begin
            vars_next  = {t1 + t2, a, b, c, d + t1, e, f, g};
            // schedule window rotates: new word enters at the tail
            blk_next   = {blk_reg[479:0], w + s0 + blk_reg[223:192] + s1};
            round_next = round_reg + 6'd1;
        end
        if (cmd.finish_comp)
        begin
            for (int i = 0; i < 8; i++)
                chain_next[i*32 +: 32] = chain_reg[i*32 +: 32] + vars_reg[i*32 +: 32];
        end
        if (cmd.clear_fill)
            fill_next = '0;
        if (cmd.out_shift)
            chain_next = {chain_reg[223:0], chain_reg[255:224]};
        if (cmd.reset_msg)
        begin
            chain_next = InitialH;
            fill_next  = '0;
            bits_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= InitialH;
            fill_reg  <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        vars_reg <= vars_next;
    end

    assign status.block_full  = fill_reg[6];
    assign status.rounds_done = (round_reg == 6'd63);
    assign status.fill        = fill_reg[5:0];
    assign head_word          = chain_reg[255:224];
endmodule

FILE: sv/sha256_ctrl.sv
module sha256_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sha256_pkg::in_item_t   in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             out_index,
    output sha256_pkg::dp_cmd_t    cmd,
    input  sha256_pkg::dp_status_t status
);
    import sha256_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_COMP, S_FIN, S_PAD, S_ZERO, S_LEN, S_OUT
    } state_t;

    state_t     state_reg;
    logic       closing_reg, final_reg, padded_reg;
    logic [2:0] idx_reg;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:  cmd.load_byte = accept && in_item.byte_present;
            S_CHECK: cmd.start_comp = status.block_full;
            S_COMP:  cmd.round_step = 1'b1;
            S_FIN:
            begin
                cmd.finish_comp = 1'b1;
                cmd.clear_fill  = 1'b1;
            end
            S_PAD:   cmd.load_pad = 1'b1;
            S_ZERO:
            begin
                cmd.load_zero  = !status.block_full && status.fill != LengthPos;
                cmd.start_comp = status.block_full;
            end
            S_LEN:
            begin
                cmd.load_len   = !status.block_full;
                cmd.start_comp = status.block_full;
            end
            S_OUT:
            begin
                cmd.out_shift = !out_stall;
                cmd.reset_msg = !out_stall && idx_reg == 3'd7;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            closing_reg <= 1'b0;
            final_reg   <= 1'b0;
            padded_reg  <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (accept && (in_item.byte_present || in_item.end_of_message))
                    begin
                        closing_reg <= in_item.end_of_message;
                        final_reg   <= 1'b0;
                        padded_reg  <= 1'b0;
                        state_reg   <= S_CHECK;
                    end
                S_CHECK:
                    if (status.block_full)
                        state_reg <= S_COMP;
                    else if (closing_reg)
                        state_reg <= S_PAD;
                    else
                        state_reg <= S_IDLE;
                S_COMP:
                    if (status.rounds_done)
                        state_reg <= S_FIN;
                S_FIN:
                    if (final_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (closing_reg && padded_reg)
                        state_reg <= S_ZERO;
                    else if (closing_reg)
                        state_reg <= S_PAD;
                    else
                        state_reg <= S_IDLE;
                S_PAD:
                begin
                    padded_reg <= 1'b1;
                    state_reg  <= S_ZERO;
                end
                S_ZERO:
                    if (status.block_full)
                        state_reg <= S_COMP;
                    else if (status.fill == LengthPos)
                        state_reg <= S_LEN;
                S_LEN:
                    if (status.block_full)
                    begin
                        final_reg <= 1'b1;
                        state_reg <= S_COMP;
                    end
                S_OUT:
                    if (!out_stall)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                            state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/sha256_message_hasher.sv
// streaming sha-256 hasher
// input channel: in_valid / in_stall carry one item per handshake: a message
// byte (byte_present) and an end_of_message flag. an item with neither is
// taken and dropped.
// output channel: out_valid / out_stall carry the eight digest words, index 0
// first, last_word set on index 7, after the closing item.
// a plain byte is loaded, then checked; a byte that completes a block is
// loaded, checked, run through 64 rounds one per cycle in a single round
// unit, then finished. closing shifts padding bytes in one per cycle and
// compresses one or two blocks, then sends the eight digest words.
// one item is worked at a time; in_stall is high while busy.
// reset (rst_n, async, low) loads the initial hash values and clears the
// byte and bit counts.
// while the receiver stalls, the current digest word holds on the port and
// nothing else advances.
module sha256_message_hasher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sha256_pkg::in_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sha256_pkg::out_item_t out_item
);
    import sha256_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [2:0] idx;
    logic [31:0] head_word;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_index (idx),
        .cmd       (cmd),
        .status    (status)
    );

    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (in_item.msg_byte),
        .cmd       (cmd),
        .status    (status),
        .head_word (head_word)
    );

    assign out_item.digest_word = head_word;
    assign out_item.word_index  = idx;
    assign out_item.last_word   = (idx == 3'd7);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken during output");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("digest word changed under stall");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !status.block_full) else $error("full block left idle");
endmodule

FILE: sim/sha256_checker.sv
`timescale 1ns / 1ps

module sha256_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  sha256_pkg::in_item_t  in_item,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  sha256_pkg::out_item_t out_item,
    output int                    fail_count,
    output int                    pending,
    output int                    digests_seen
);
    import sha256_pkg::*;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0] hash_h [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] bit_len;
    out_item_t   digest_q [$];

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int j = 0; j < 16; j++)
            w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
        for (int j = 16; j < 64; j++)
        begin
            s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
            s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
            w[j] = w[j-16] + s0 + w[j-7] + s1;
        end
        for (int j = 0; j < 8; j++)
            v[j] = hash_h[j];
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hash_h[j] += v[j];
    endtask

    task automatic hash_item(in_item_t it);
        int p;
        out_item_t o;
        if (it.byte_present)
        begin
            blk[fill] = it.msg_byte;
            fill++;
            bit_len += 64'd8;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        end
        if (!it.end_of_message)
            return;
        p = fill;
        blk[p++] = PadMark;
        if (p > 56)
        begin
            while (p < 64)
                blk[p++] = 8'h00;
            compress();
            p = 0;
        end
        while (p < 56)
            blk[p++] = 8'h00;
        for (int j = 0; j < 8; j++)
            blk[56 + j] = bit_len[63 - 8*j -: 8];
        compress();
        for (int j = 0; j < 8; j++)
        begin
            o.digest_word = hash_h[j];
            o.word_index  = 3'(j);
            o.last_word   = (j == 7);
            digest_q.push_back(o);
        end
        hash_h = H0;
        fill = 0;
        bit_len = '0;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        digests_seen = 0;
        hash_h = H0;
        fill = 0;
        bit_len = '0;
    end

    assign pending = digest_q.size();

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_q.size() == 0)
                report("unexpected word", out_item.digest_word, 32'h0);
            else
            begin
                automatic out_item_t w = digest_q.pop_front();
                if (out_item.digest_word !== w.digest_word)
                    report("digest_word", out_item.digest_word, w.digest_word);
                if (out_item.word_index !== w.word_index)
                    report("word_index", out_item.word_index, w.word_index);
                if (out_item.last_word !== w.last_word)
                    report("last_word", out_item.last_word, w.last_word);
                if (w.last_word)
                    digests_seen++;
            end
        end
        if (rst_n && in_valid && !in_stall)
            hash_item(in_item);
    end
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sha256_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    int        fail_count;
    int        pending;
    int        digests_seen;
    int        cycle_count;
    int        long_hold;
    int        sent;
    int        burst_left;

    sha256_message_hasher dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    sha256_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .fail_count(fail_count), .pending(pending), .digests_seen(digests_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("timeout");
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // receiver stall pattern, with long hold-offs on request
    initial
    begin
        out_stall = 1'b0;
        long_hold = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                out_stall <= 1'b1;
                long_hold--;
            end
            else if (cycle_count % 300 < 100)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send(logic [7:0] b, logic bp, logic eom);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(1, 4))
            begin
                in_item <= in_item_t'(10'($urandom));
                @(negedge clk);
            end
        end
        burst_left--;
        in_item <= '{msg_byte: b, byte_present: bp, end_of_message: eom};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (burst_left == 0)
            in_valid <= 1'b0;
        sent++;
    endtask

    task automatic send_message(int len, logic empty_close);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, (i == len - 1) && !empty_close);
        end
        if (empty_close || len == 0)
            send(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        if (burst_left != 0)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
        end
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        sent = 0;
        burst_left = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty message, extremes, ignored bytes
        send(8'hff, 1'b0, 1'b1);
        send(8'h00, 1'b1, 1'b0);
        send(8'hff, 1'b0, 1'b0);
        send(8'hff, 1'b1, 1'b1);
        send(8'h61, 1'b1, 1'b0);
        send(8'h62, 1'b1, 1'b0);
        send(8'h63, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b1);
        drain();

        // sender keeps offering while receiver holds off; padding spills over
        long_hold = 800;
        send_message(57, 1'b1);
        send_message(3, 1'b0);
        drain();

        // closing byte completes a block
        send_message(64, 1'b0);

        while (sent < 130)
            send_message($urandom_range(0, 8), 1'($urandom_range(0, 1)));

        drain();
        repeat (300) @(negedge clk);
        $display("sent %0d items, checked %0d digests incl. empty, padding edges, stalls",
                 sent, digests_seen);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
